>>> src/lmc_pkg.sv
// ----------------------------------------------------------------------------
// lmc_pkg
// Types, codes and constants shared by the log message chunker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lmc_pkg;

	// fixed sizes
	localparam int unsigned HEADER_BYTES = 12;
	localparam int unsigned MAX_CHUNKS   = 128;
	localparam int unsigned LEN_W        = 20;
	localparam int unsigned CSZ_W        = 16;
	localparam int unsigned IDENT_W      = 64;
	localparam int unsigned CFG_IDX_W    = 1;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned STEP_W       = $clog2(LEN_W);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = 1'd1;

	localparam logic [15:0] MAGIC_RESET = 16'h1e0f;

	// input opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_BYTE   = 2'd2;

	// start status codes
	localparam logic [1:0] STAT_SINGLE   = 2'd0;
	localparam logic [1:0] STAT_CHUNKED  = 2'd1;
	localparam logic [1:0] STAT_REJECTED = 2'd2;

	// message modes
	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_SINGLE  = 2'd1;
	localparam logic [1:0] MODE_CHUNKED = 2'd2;
	localparam logic [1:0] MODE_DROP    = 2'd3;

	typedef struct packed {
		logic              opcode;
		logic [LEN_W-1:0]  message_length;
		logic [IDENT_W-1:0] message_ident;
		logic [7:0]        payload_byte;
	} lmc_in_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         status;
		logic [20:0]        total_out_bytes;
		logic [15:0]        hdr_magic;
		logic [IDENT_W-1:0] hdr_ident;
		logic [6:0]         seq_number;
		logic [7:0]         seq_count;
		logic [7:0]         out_byte;
		logic               chunk_end;
		logic               last;
	} lmc_out_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic div_step;
		logic fin_load;
		logic pend_load;
	} lmc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic start_div;
		logic byte_hdr;
	} lmc_sts_t;

endpackage

`default_nettype wire

>>> src/lmc_ctrl.sv
// ----------------------------------------------------------------------------
// lmc_ctrl
// Sequencer: input handshake, division step count, result ordering.
// ----------------------------------------------------------------------------
`default_nettype none

module lmc_ctrl
	import lmc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_stall,
	input  wire lmc_sts_t sts,
	output lmc_cmd_t      cmd
);

	localparam logic [1:0] ST_READY = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_FIN   = 2'd2;
	localparam logic [1:0] ST_BYTE  = 2'd3;

	logic [1:0]        state_q;
	logic [1:0]        state_d;
	logic [STEP_W-1:0] step_q;
	logic              take;

	// input transfer only in the ready state and when the output register can take a result
	assign item_stall = (state_q != ST_READY) || !sts.out_free;
	assign take       = item_valid && !item_stall;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.accept    = take;
		case (state_q)
			ST_READY: begin
				if (take && sts.start_div)
					state_d = ST_DIV;
				else if (take && sts.byte_hdr)
					state_d = ST_BYTE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(LEN_W - 1))
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin_load = 1'b1;
					state_d      = ST_READY;
				end
			end
			ST_BYTE: begin
				if (sts.out_free) begin
					cmd.pend_load = 1'b1;
					state_d       = ST_READY;
				end
			end
			default: state_d = ST_READY;
		endcase
	end

	// state and division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV)
				step_q <= step_q + STEP_W'(1);
			else
				step_q <= '0;
		end
	end

endmodule

`default_nettype wire

>>> src/lmc_dp.sv
// ----------------------------------------------------------------------------
// lmc_dp
// Datapath: configuration, message state, chunk count divider, result
// register and pending payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lmc_dp
	import lmc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire lmc_in_t               item,
	input  wire logic                  result_stall,
	output logic                       result_valid,
	output lmc_out_t                   result,
	input  wire lmc_cmd_t              cmd,
	output lmc_sts_t                   sts
);

	// configuration
	logic [CSZ_W-1:0] chunk_size_q;
	logic [15:0]      magic_word_q;

	// message state
	logic [1:0]         mode_q;
	logic [7:0]         chunk_total_q;
	logic [7:0]         chunk_index_q;
	logic [CSZ_W-1:0]   pay_q;
	logic [CSZ_W-1:0]   left_q;
	logic [LEN_W-1:0]   rem_q;
	logic [IDENT_W-1:0] ident_q;

	// divider: dividend shifts out, quotient shifts in
	logic [LEN_W-1:0] dvd_q;
	logic [CSZ_W-1:0] prem_q;

	// result register and pending byte
	logic     out_valid_q;
	lmc_out_t out_q;
	lmc_out_t pend_q;

	logic             is_start;
	logic             fits;
	logic             small_cs;
	logic             live;
	logic             hdr;
	logic [CSZ_W-1:0] left_eff;
	logic [CSZ_W-1:0] left_dec;
	logic [LEN_W-1:0] rem_dec;
	logic             end_flag;
	logic             load_item;
	logic             load_any;
	lmc_out_t         start_res;
	lmc_out_t         hdr_res;
	lmc_out_t         byte_res;
	lmc_out_t         fin_res;
	logic [CSZ_W:0]   div_try;
	logic             div_ge;
	logic             rest_nz;
	logic             over;
	logic [23:0]      prod;
	logic [20:0]      tail;

	assign is_start = (item.opcode == OP_START);
	assign fits     = (chunk_size_q == '0) ||
			  (item.message_length <= LEN_W'(chunk_size_q));
	assign small_cs = (chunk_size_q <= CSZ_W'(HEADER_BYTES));
	assign live     = (mode_q != MODE_IDLE) && (rem_q != '0);

	// payload byte bookkeeping
	assign hdr      = (mode_q == MODE_CHUNKED) && (left_q == '0);
	always_comb begin
		if (!hdr)
			left_eff = left_q;
		else if (rem_q < LEN_W'(pay_q))
			left_eff = rem_q[CSZ_W-1:0];
		else
			left_eff = pay_q;
	end
	assign left_dec = (left_eff != '0) ? left_eff - CSZ_W'(1) : '0;
	assign rem_dec  = rem_q - LEN_W'(1);
	assign end_flag = (mode_q == MODE_CHUNKED) ? (left_dec == '0) : (rem_dec == '0);

	// status to controller
	assign sts.out_free  = !out_valid_q || !result_stall;
	assign sts.start_div = is_start && !fits && !small_cs;
	assign sts.byte_hdr  = !is_start && live && hdr;

	// candidate results
	always_comb begin
		start_res      = '0;
		start_res.kind = KIND_STATUS;
		start_res.last = 1'b1;
		if (fits) begin
			start_res.status          = STAT_SINGLE;
			start_res.total_out_bytes = 21'(item.message_length);
		end else begin
			start_res.status = STAT_REJECTED;
		end

		hdr_res            = '0;
		hdr_res.kind       = KIND_HEADER;
		hdr_res.hdr_magic  = magic_word_q;
		hdr_res.hdr_ident  = ident_q;
		hdr_res.seq_number = chunk_index_q[6:0];
		hdr_res.seq_count  = chunk_total_q;

		byte_res           = '0;
		byte_res.kind      = KIND_BYTE;
		byte_res.out_byte  = item.payload_byte;
		byte_res.chunk_end = end_flag;
		byte_res.last      = 1'b1;
	end

	// one restoring division step
	assign div_try = {prem_q, dvd_q[LEN_W-1]};
	assign div_ge  = (div_try >= {1'b0, pay_q});

	// chunk count and output size from quotient and remainder
	assign rest_nz = (prem_q != '0);
	assign over    = (dvd_q > LEN_W'(MAX_CHUNKS)) ||
			 ((dvd_q == LEN_W'(MAX_CHUNKS)) && rest_nz);
	assign prod    = dvd_q[7:0] * chunk_size_q;
	assign tail    = rest_nz ? 21'(prem_q) + 21'(HEADER_BYTES) : '0;
	always_comb begin
		fin_res      = '0;
		fin_res.kind = KIND_STATUS;
		fin_res.last = 1'b1;
		if (over) begin
			fin_res.status = STAT_REJECTED;
		end else begin
			fin_res.status          = STAT_CHUNKED;
			fin_res.total_out_bytes = prod[20:0] + tail;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= '0;
			magic_word_q <= MAGIC_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_CHUNK_SIZE)
				chunk_size_q <= cfg_data;
			else if (cfg_index == CFG_MAGIC_WORD)
				magic_word_q <= cfg_data;
		end
	end

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			chunk_total_q <= '0;
			chunk_index_q <= '0;
			pay_q         <= '0;
			left_q        <= '0;
			rem_q         <= '0;
			ident_q       <= '0;
		end else if (cmd.accept && is_start) begin
			ident_q       <= item.message_ident;
			chunk_index_q <= '0;
			left_q        <= '0;
			rem_q         <= item.message_length;
			if (fits) begin
				mode_q        <= (item.message_length == '0) ? MODE_IDLE : MODE_SINGLE;
				chunk_total_q <= 8'd1;
			end else if (small_cs) begin
				mode_q        <= MODE_DROP;
				chunk_total_q <= '0;
			end else begin
				mode_q <= MODE_IDLE;
				pay_q  <= chunk_size_q - CSZ_W'(HEADER_BYTES);
			end
		end else if (cmd.accept) begin
			if (!live) begin
				mode_q <= MODE_IDLE;
			end else begin
				rem_q <= rem_dec;
				if (rem_dec == '0)
					mode_q <= MODE_IDLE;
				if (mode_q == MODE_CHUNKED) begin
					left_q <= left_dec;
					if (left_dec == '0)
						chunk_index_q <= chunk_index_q + 8'd1;
				end
			end
		end else if (cmd.fin_load) begin
			if (over) begin
				mode_q        <= MODE_DROP;
				chunk_total_q <= '0;
			end else begin
				mode_q        <= MODE_CHUNKED;
				chunk_total_q <= dvd_q[7:0] + {7'd0, rest_nz};
			end
		end
	end

	// divider registers
	always_ff @(posedge clk) begin
		if (cmd.accept && is_start) begin
			dvd_q  <= item.message_length;
			prem_q <= '0;
		end else if (cmd.div_step) begin
			prem_q <= div_ge ? CSZ_W'(div_try - {1'b0, pay_q}) : div_try[CSZ_W-1:0];
			dvd_q  <= {dvd_q[LEN_W-2:0], div_ge};
		end
	end

	// result register
	assign load_item = cmd.accept &&
			   (is_start ? (fits || small_cs) : (live && (mode_q != MODE_DROP)));
	assign load_any  = load_item || cmd.fin_load || cmd.pend_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_any)
			out_valid_q <= 1'b1;
		else if (out_valid_q && !result_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			if (is_start)
				out_q <= start_res;
			else if (hdr)
				out_q <= hdr_res;
			else
				out_q <= byte_res;
		end else if (cmd.fin_load) begin
			out_q <= fin_res;
		end else if (cmd.pend_load) begin
			out_q <= pend_q;
		end
		if (cmd.accept && !is_start)
			pend_q <= byte_res;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

>>> src/log_message_chunker_core.sv
// ----------------------------------------------------------------------------
// log_message_chunker_core
// Splits log messages into headed chunks and passes payload bytes through.
//
//   channel  direction  handshake              payload
//   item     in         item_valid/item_stall  lmc_in_t
//   result   out        result_valid/result_stall lmc_out_t
//   cfg      in         cfg_we                 cfg_index, cfg_data
//
// A byte that opens a chunk gives a header and then the byte once the result
// register is free again.
// A start that needs a chunk count runs the restoring divider, which resolves
// one quotient bit per cycle over the 20-bit length; a final state then forms
// the count and output size. The input stalls until the start is through.
// The one-entry result register takes a new result while the previous one
// leaves; a stalled result holds the input side off.
// Reset clears all control state and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module log_message_chunker_core
	import lmc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire lmc_in_t               item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output lmc_out_t                   result
);

	lmc_cmd_t cmd;
	lmc_sts_t sts;

	// sequencer
	lmc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath
	lmc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for log_message_chunker_core. Messages are queued as
// start and byte items, driven with random sender gaps and receiver stalls,
// and every accepted result is checked against a chunking model kept here.
// Chunk size and magic word change between phases while the block is idle.
// ----------------------------------------------------------------------------

module testbench
	import lmc_pkg::*;
();

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;

	// idle regimes
	localparam int REGIME_RECV_BUSY = 0;
	localparam int REGIME_SEND_BUSY = 1;
	localparam int REGIME_NONE      = 2;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  item_valid;
	logic                  item_stall;
	lmc_in_t               item;
	logic                  result_valid;
	logic                  result_stall;
	lmc_out_t              result;

	log_message_chunker_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// stimulus and expected output queues
	lmc_in_t  items_to_send[$];
	lmc_out_t due_results[$];
	logic     item_taken;
	int       send_idle_pct;
	int       recv_stall_pct;
	int       mismatch_count;
	int       cycle_count;

	// model copy of registers and message state
	logic [15:0]        chunk_size_cfg;
	logic [15:0]        magic_cfg;
	logic [1:0]         msg_mode;
	logic [7:0]         chunk_total;
	logic [7:0]         chunk_index;
	logic [LEN_W-1:0]   payload_per_chunk;
	logic [LEN_W-1:0]   left_in_chunk;
	logic [LEN_W-1:0]   bytes_remaining;
	logic [IDENT_W-1:0] held_ident;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// work out the results of one accepted item and queue them
	task automatic chunker_predict(input lmc_in_t it);
		lmc_out_t        res;
		int unsigned     len;
		int unsigned     pay;
		int unsigned     full;
		int unsigned     rest;
		int unsigned     count;
		longint unsigned total;
		len = it.message_length;
		res = '0;
		pay = 0;
		full = 0;
		rest = 0;
		if (it.opcode == OP_START) begin
			res.kind = KIND_STATUS;
			res.last = 1'b1;
			held_ident = it.message_ident;
			chunk_index = '0;
			left_in_chunk = '0;
			bytes_remaining = it.message_length;
			if (chunk_size_cfg == 0 || len <= chunk_size_cfg) begin
				res.status = STAT_SINGLE;
				res.total_out_bytes = {1'b0, it.message_length};
				chunk_total = 8'd1;
				payload_per_chunk = it.message_length;
				msg_mode = (len == 0) ? MODE_IDLE : MODE_SINGLE;
			end else begin
				// no payload room means reject, like an oversized count
				count = MAX_CHUNKS + 1;
				if (chunk_size_cfg > HEADER_BYTES) begin
					pay = chunk_size_cfg - HEADER_BYTES;
					full = len / pay;
					rest = len - full * pay;
					count = full + ((rest != 0) ? 1 : 0);
				end
				if (count > MAX_CHUNKS) begin
					res.status = STAT_REJECTED;
					res.total_out_bytes = '0;
					chunk_total = '0;
					payload_per_chunk = '0;
					msg_mode = MODE_DROP;
				end else begin
					total = longint'(full) * chunk_size_cfg
						+ ((rest != 0) ? rest + HEADER_BYTES : 0);
					res.status = STAT_CHUNKED;
					res.total_out_bytes = total[20:0];
					chunk_total = count[7:0];
					payload_per_chunk = pay[LEN_W-1:0];
					msg_mode = MODE_CHUNKED;
				end
			end
			due_results.push_back(res);
		end else if (msg_mode == MODE_IDLE || bytes_remaining == 0) begin
			msg_mode = MODE_IDLE;
		end else if (msg_mode == MODE_DROP) begin
			bytes_remaining = bytes_remaining - 1'b1;
			if (bytes_remaining == 0)
				msg_mode = MODE_IDLE;
		end else begin
			// header ahead of the first byte of each chunk
			if (msg_mode == MODE_CHUNKED && left_in_chunk == 0) begin
				res.kind = KIND_HEADER;
				res.hdr_magic = magic_cfg;
				res.hdr_ident = held_ident;
				res.seq_number = chunk_index[6:0];
				res.seq_count = chunk_total;
				due_results.push_back(res);
				res = '0;
				left_in_chunk = (bytes_remaining < payload_per_chunk) ?
					bytes_remaining : payload_per_chunk;
			end
			res.kind = KIND_BYTE;
			res.out_byte = it.payload_byte;
			res.last = 1'b1;
			bytes_remaining = bytes_remaining - 1'b1;
			if (msg_mode == MODE_CHUNKED) begin
				if (left_in_chunk != 0)
					left_in_chunk = left_in_chunk - 1'b1;
				if (left_in_chunk == 0) begin
					res.chunk_end = 1'b1;
					chunk_index = chunk_index + 1'b1;
				end
			end else if (bytes_remaining == 0) begin
				res.chunk_end = 1'b1;
			end
			if (bytes_remaining == 0)
				msg_mode = MODE_IDLE;
			due_results.push_back(res);
		end
	endtask

	// names of the fields that differ
	function automatic string differing_fields(input lmc_out_t want, input lmc_out_t got);
		string s;
		s = "";
		if (got.kind !== want.kind)                       s = {s, " kind"};
		if (got.status !== want.status)                   s = {s, " status"};
		if (got.total_out_bytes !== want.total_out_bytes) s = {s, " total_out_bytes"};
		if (got.hdr_magic !== want.hdr_magic)             s = {s, " hdr_magic"};
		if (got.hdr_ident !== want.hdr_ident)             s = {s, " hdr_ident"};
		if (got.seq_number !== want.seq_number)           s = {s, " seq_number"};
		if (got.seq_count !== want.seq_count)             s = {s, " seq_count"};
		if (got.out_byte !== want.out_byte)               s = {s, " out_byte"};
		if (got.chunk_end !== want.chunk_end)             s = {s, " chunk_end"};
		if (got.last !== want.last)                       s = {s, " last"};
		return s;
	endfunction

	// monitor: check result transfers, then model item transfers
	always @(posedge clk) begin
		lmc_out_t want;
		string    diffs;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result %h", result);
				end else begin
					want = due_results.pop_front();
					diffs = differing_fields(want, result);
					if (diffs != "") begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch in%s: expected %h, got %h",
								diffs, want, result);
					end
				end
			end
			if (item_valid && !item_stall) begin
				chunker_predict(item);
				item_taken = 1'b1;
			end
		end
	end

	// driver: hold a stalled item, otherwise present the next one or idle
	always @(negedge clk) begin
		if (!(item_valid && !item_taken)) begin
			if (item_taken) begin
				void'(items_to_send.pop_front());
				item_taken = 1'b0;
			end
			if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item_valid <= 1'b1;
				item <= items_to_send[0];
			end else begin
				item_valid <= 1'b0;
			end
		end
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic add_start(input logic [LEN_W-1:0] len, input logic [IDENT_W-1:0] ident);
		lmc_in_t it;
		it = '0;
		it.opcode = OP_START;
		it.message_length = len;
		it.message_ident = ident;
		it.payload_byte = 8'($urandom);
		items_to_send.push_back(it);
	endtask

	task automatic add_byte(input logic [7:0] data);
		lmc_in_t it;
		logic [31:0] rnd;
		rnd = $urandom;
		it = '0;
		it.opcode = OP_BYTE;
		// start-only fields carry noise on bytes
		it.message_length = rnd[LEN_W-1:0];
		it.message_ident = {$urandom, $urandom};
		it.payload_byte = data;
		items_to_send.push_back(it);
	endtask

	// mostly whole messages, some cut short or overrun, some noise
	task automatic gen_traffic(input int max_len, input int budget);
		int               n;
		int               pick;
		int               nbytes;
		logic [31:0]      rnd;
		logic [LEN_W-1:0] len;
		n = 0;
		while (n < budget) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				rnd = $urandom;
				if ($urandom_range(9) == 0)
					len = rnd[LEN_W-1:0];
				else
					len = LEN_W'($urandom_range(0, max_len));
				add_start(len, {$urandom, $urandom});
				n++;
				if (len > 300)
					nbytes = $urandom_range(1, 6);
				else if ($urandom_range(9) == 0)
					nbytes = $urandom_range(0, len);
				else
					nbytes = len;
				for (int i = 0; i < nbytes; i++)
					add_byte(8'($urandom));
				n += nbytes;
				if ($urandom_range(9) == 0)
					add_byte(8'($urandom));
			end else if (pick < 90) begin
				rnd = $urandom;
				add_start(rnd[LEN_W-1:0], {$urandom, $urandom});
				n++;
			end else begin
				add_byte(8'($urandom));
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CHUNK_SIZE)
			chunk_size_cfg = val;
		else
			magic_cfg = val;
	endtask

	task automatic set_regime(input int regime);
		case (regime)
			REGIME_RECV_BUSY: begin
				send_idle_pct = 6;
				recv_stall_pct = 60;
			end
			REGIME_SEND_BUSY: begin
				send_idle_pct = 60;
				recv_stall_pct = 6;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	task automatic configure(input logic [15:0] csize, input logic [15:0] magic,
		input int regime);
		write_reg(CFG_CHUNK_SIZE, csize);
		write_reg(CFG_MAGIC_WORD, magic);
		set_regime(regime);
	endtask

	// wait for all transfers, then let a dropped byte finish
	task automatic settle();
		while (items_to_send.size() != 0 || item_valid)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		item_taken = 1'b0;
		mismatch_count = 0;
		chunk_size_cfg = '0;
		magic_cfg = MAGIC_RESET;
		msg_mode = MODE_IDLE;
		chunk_total = '0;
		chunk_index = '0;
		payload_per_chunk = '0;
		left_in_chunk = '0;
		bytes_remaining = '0;
		held_ident = '0;
		set_regime(REGIME_RECV_BUSY);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset registers: byte while idle, empty message, single chunk
		add_byte(8'h5a);
		add_start('0, 64'hdead_beef_0000_0001);
		add_byte(8'h33);
		add_start(20'd2, {IDENT_W{1'b1}});
		add_byte(8'h00);
		add_byte(8'hff);
		settle();

		// two payload bytes per chunk, reset magic in headers
		write_reg(CFG_CHUNK_SIZE, 16'd14);
		add_start(20'd5, 64'h0123_4567_89ab_cdef);
		for (int i = 0; i < 5; i++)
			add_byte(8'h10 + 8'(i));
		add_start(20'd14, 64'h1);
		add_byte(8'ha5);
		// start during a message, then a rejected count with dropped bytes
		add_start({LEN_W{1'b1}}, {IDENT_W{1'b1}});
		add_byte(8'h01);
		add_byte(8'h02);
		add_start(20'd3, '0);
		for (int i = 0; i < 3; i++)
			add_byte(8'hc0 + 8'(i));
		settle();

		// chunk size with no payload room
		configure(16'd12, 16'h0000, REGIME_RECV_BUSY);
		add_start(20'd13, 64'h55);
		add_byte(8'h77);
		add_start(20'd12, 64'h66);
		add_byte(8'h88);
		settle();

		// one payload byte per chunk: count limit edges, message left open
		configure(16'd13, 16'hffff, REGIME_RECV_BUSY);
		add_byte(8'($urandom));
		add_byte(8'($urandom));
		add_start(20'd128, {$urandom, $urandom});
		for (int i = 0; i < 128; i++)
			add_byte(8'($urandom));
		add_start(20'd129, {$urandom, $urandom});
		for (int i = 0; i < 3; i++)
			add_byte(8'($urandom));
		gen_traffic(140, 100);
		settle();

		configure(16'd0, 16'h0000, REGIME_RECV_BUSY);
		gen_traffic(40, 100);
		settle();

		configure(16'($urandom_range(14, 40)), 16'h0000, REGIME_SEND_BUSY);
		gen_traffic(120, 110);
		settle();

		configure(16'hffff, 16'($urandom), REGIME_SEND_BUSY);
		gen_traffic(60, 80);
		settle();

		configure(16'($urandom_range(1, 12)), 16'($urandom), REGIME_NONE);
		gen_traffic(20, 70);
		settle();

		configure(16'($urandom_range(13, 64)), 16'($urandom), REGIME_NONE);
		gen_traffic(200, 130);
		settle();

		if (mismatch_count == 0 && due_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
src/lmc_pkg.sv
src/lmc_ctrl.sv
src/lmc_dp.sv
src/log_message_chunker_core.sv
verif/testbench.sv
